[hw/rtl/time_mantissa_factor_codec_top_assert.svh]
// assertion macros for the time mantissa factor codec
`ifndef TIME_MANTISSA_FACTOR_CODEC_TOP_ASSERT_SVH
`define TIME_MANTISSA_FACTOR_CODEC_TOP_ASSERT_SVH

// antecedent implies consequent on the next clock
`define TMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tmf check failed");

// condition holds on every clock
`define TMF_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("tmf check failed");

`endif

[hw/rtl/tmf_pkg.sv]
// shared types and constants for the time mantissa factor codec
package tmf_pkg;
    localparam int FACTOR_W = 24;
    localparam int TIME_W = 32;
    localparam int CODE_W = 8;
    localparam int TOUT_W = 29;
    localparam int REG_COUNT = 8;
    localparam int REG_IDX_W = 3;
    localparam logic [TOUT_W-1:0] TIME_MAX = '1;

    localparam logic KIND_ENCODE = 1'b0;
    localparam logic KIND_DECODE = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [TIME_W-1:0] time_ms;
        logic [CODE_W-1:0] code;
    } in_item_t;

    typedef struct packed {
        logic [CODE_W-1:0] code_out;
        logic [TOUT_W-1:0] time_out;
    } out_item_t;

    typedef logic [FACTOR_W-1:0] factor_t;

    function automatic factor_t reset_factor(input logic [REG_IDX_W-1:0] idx);
        factor_t f;
        case (idx)
            3'd0: f = 24'd100;
            3'd1: f = 24'd1000;
            3'd2: f = 24'd5000;
            3'd3: f = 24'd10000;
            3'd4: f = 24'd60000;
            3'd5: f = 24'd300000;
            3'd6: f = 24'd600000;
            3'd7: f = 24'd3600000;
            default: f = 24'd1;
        endcase
        return f;
    endfunction
endpackage

[hw/rtl/time_mantissa_factor_codec_top.sv]
// top level of the time mantissa factor codec
// Every item passes through a fixed chain of cells: NUM_FACTORS compare cells that pick
// the first fitting factor, then one restoring division cell per quotient bit (34 for a
// 32-bit time), then one output stage. One item is accepted every cycle while the output
// is taken. Decode items ride the same chain and use the multiply in the last stage.
// Factor writes must happen while the chain is empty.
module time_mantissa_factor_codec_top #(
    parameter int MANTISSA_BITS = 5,
    parameter int NUM_FACTORS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tmf_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output tmf_pkg::out_item_t  out_item,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [23:0]         cfg_data
);
    import tmf_pkg::*;

    localparam int IDX_W = (NUM_FACTORS > 1) ? $clog2(NUM_FACTORS) : 1;
    localparam int NUM_W = TIME_W + 2;
    localparam int DEN_W = FACTOR_W + 1;
    localparam logic [MANTISSA_BITS-1:0] MANT_MAX = '1;
    localparam int PROD_W = FACTOR_W + MANTISSA_BITS;

    factor_t factor_reg [REG_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                factor_reg[i] <= reset_factor(REG_IDX_W'(i));
            end
        end
        else if (cfg_we)
        begin
            factor_reg[cfg_index] <= cfg_data;
        end
    end

    logic adv;
    logic out_valid_reg;
    out_item_t out_item_reg;

    assign adv = !out_valid_reg || out_ready;
    assign in_ready = adv;

    logic sv [NUM_FACTORS+1];
    in_item_t sd [NUM_FACTORS+1];
    logic sf [NUM_FACTORS+1];
    logic [IDX_W-1:0] si [NUM_FACTORS+1];

    assign sv[0] = in_valid;
    assign sd[0] = in_item;
    assign sf[0] = 1'b0;
    assign si[0] = '0;

    for (genvar g = 0; g < NUM_FACTORS; g++)
    begin : g_sel
        tmf_select_cell #(
            .MANTISSA_BITS(MANTISSA_BITS),
            .CELL_IDX(g),
            .IDX_W(IDX_W)
        ) u_cell (
            .clk(clk), .rst_n(rst_n), .adv(adv),
            .v_in(sv[g]), .d_in(sd[g]), .found_in(sf[g]), .idx_in(si[g]),
            .factor(factor_reg[g]),
            .v_out(sv[g+1]), .d_out(sd[g+1]), .found_out(sf[g+1]), .idx_out(si[g+1])
        );
    end

    // last factor wins when none fits
    logic [IDX_W-1:0] sel_idx;
    factor_t sel_f;
    logic [DEN_W-1:0] eff2;

    assign sel_idx = sf[NUM_FACTORS] ? si[NUM_FACTORS] : IDX_W'(NUM_FACTORS - 1);
    assign sel_f = factor_reg[REG_IDX_W'(sel_idx)];
    assign eff2 = (sel_f == '0) ? DEN_W'(2) : {sel_f, 1'b0};

    logic dv [NUM_W+1];
    in_item_t dd [NUM_W+1];
    logic [IDX_W-1:0] di [NUM_W+1];
    logic [DEN_W-1:0] dden [NUM_W+1];
    logic [NUM_W-1:0] dnum [NUM_W+1];
    logic [DEN_W:0] drem [NUM_W+1];
    logic [NUM_W-1:0] dquo [NUM_W+1];

    assign dv[0] = sv[NUM_FACTORS];
    assign dd[0] = sd[NUM_FACTORS];
    assign di[0] = sel_idx;
    assign dden[0] = eff2;
    assign dnum[0] = {1'b0, sd[NUM_FACTORS].time_ms, 1'b0} + NUM_W'(eff2 >> 1);
    assign drem[0] = '0;
    assign dquo[0] = '0;

    for (genvar k = 0; k < NUM_W; k++)
    begin : g_div
        tmf_div_cell #(.NUM_W(NUM_W), .DEN_W(DEN_W), .IDX_W(IDX_W)) u_cell (
            .clk(clk), .rst_n(rst_n), .adv(adv),
            .v_in(dv[k]), .d_in(dd[k]), .idx_in(di[k]), .den_in(dden[k]),
            .num_in(dnum[k]), .rem_in(drem[k]), .quo_in(dquo[k]),
            .v_out(dv[k+1]), .d_out(dd[k+1]), .idx_out(di[k+1]), .den_out(dden[k+1]),
            .num_out(dnum[k+1]), .rem_out(drem[k+1]), .quo_out(dquo[k+1])
        );
    end

    in_item_t fin;
    logic [NUM_W-1:0] quo;
    logic [MANTISSA_BITS-1:0] mant;
    logic [CODE_W-1:0] enc_code;
    logic [MANTISSA_BITS-1:0] dmant;
    logic [IDX_W-1:0] didx;
    factor_t dfac;
    logic [PROD_W-1:0] prod;
    logic [TOUT_W-1:0] dec_time;
    out_item_t out_next;

    assign fin = dd[NUM_W];
    assign quo = dquo[NUM_W];
    assign mant = (quo > NUM_W'(MANT_MAX)) ? MANT_MAX : quo[MANTISSA_BITS-1:0];
    assign enc_code = CODE_W'(({{(32-IDX_W){1'b0}}, di[NUM_W]} << MANTISSA_BITS)
                      | 32'(mant));
    assign dmant = MANTISSA_BITS'(fin.code);
    assign didx = IDX_W'(32'(fin.code) >> MANTISSA_BITS) & IDX_W'(NUM_FACTORS - 1);
    assign dfac = (factor_reg[REG_IDX_W'(didx)] == '0) ? FACTOR_W'(1)
                  : factor_reg[REG_IDX_W'(didx)];
    assign prod = PROD_W'(dfac) * PROD_W'(dmant);
    assign dec_time = (PROD_W > TOUT_W && (prod >> TOUT_W) != '0) ? TIME_MAX
                      : TOUT_W'(prod);

    always_comb
    begin
        out_next = '0;
        if (fin.kind == KIND_ENCODE)
        begin
            out_next.code_out = enc_code;
        end
        else
        begin
            out_next.time_out = dec_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv[NUM_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_item_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item = out_item_reg;

`include "time_mantissa_factor_codec_top_assert.svh"

    `TMF_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_item))
    `TMF_ASSERT_ALWAYS(a_ready_when_free, clk, rst_n, !out_valid |-> in_ready)
    `TMF_ASSERT_ALWAYS(a_one_side_zero, clk, rst_n, !out_valid || out_item.code_out == '0 || out_item.time_out == '0)
endmodule

[hw/rtl/tmf_select_cell.sv]
// one factor compare cell of the encode chain
module tmf_select_cell #(
    parameter int MANTISSA_BITS = 5,
    parameter int CELL_IDX = 0,
    parameter int IDX_W = 3
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      v_in,
    input  tmf_pkg::in_item_t         d_in,
    input  logic                      found_in,
    input  logic [IDX_W-1:0]          idx_in,
    input  tmf_pkg::factor_t          factor,
    output logic                      v_out,
    output tmf_pkg::in_item_t         d_out,
    output logic                      found_out,
    output logic [IDX_W-1:0]          idx_out
);
    import tmf_pkg::*;

    localparam int PROD_W = FACTOR_W + MANTISSA_BITS;
    localparam logic [MANTISSA_BITS-1:0] MANT_MAX = '1;

    logic [FACTOR_W-1:0] eff;
    logic [PROD_W-1:0] limit;
    logic fits;
    logic v_reg;
    in_item_t d_reg;
    logic found_reg;
    logic [IDX_W-1:0] idx_reg;

    assign eff = (factor == '0) ? FACTOR_W'(1) : factor;
    assign limit = PROD_W'(eff) * PROD_W'(MANT_MAX);
    assign fits = ((PROD_W > TIME_W) ? (PROD_W'(d_in.time_ms) <= limit)
                  : (d_in.time_ms <= TIME_W'(limit)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg <= d_in;
            found_reg <= found_in | fits;
            idx_reg <= found_in ? idx_in : IDX_W'(CELL_IDX);
        end
    end

    assign v_out = v_reg;
    assign d_out = d_reg;
    assign found_out = found_reg;
    assign idx_out = idx_reg;
endmodule

[hw/rtl/tmf_div_cell.sv]
// one restoring division step cell of the mantissa chain
module tmf_div_cell #(
    parameter int NUM_W = 34,
    parameter int DEN_W = 25,
    parameter int IDX_W = 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 v_in,
    input  tmf_pkg::in_item_t    d_in,
    input  logic [IDX_W-1:0]     idx_in,
    input  logic [DEN_W-1:0]     den_in,
    input  logic [NUM_W-1:0]     num_in,
    input  logic [DEN_W:0]       rem_in,
    input  logic [NUM_W-1:0]     quo_in,
    output logic                 v_out,
    output tmf_pkg::in_item_t    d_out,
    output logic [IDX_W-1:0]     idx_out,
    output logic [DEN_W-1:0]     den_out,
    output logic [NUM_W-1:0]     num_out,
    output logic [DEN_W:0]       rem_out,
    output logic [NUM_W-1:0]     quo_out
);
    import tmf_pkg::*;

    logic [DEN_W+1:0] shifted;
    logic ge;
    logic v_reg;
    in_item_t d_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;

    assign shifted = {rem_in, num_in[NUM_W-1]};
    assign ge = shifted >= {1'b0, 1'b0, den_in};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg <= d_in;
            idx_reg <= idx_in;
            den_reg <= den_in;
            num_reg <= {num_in[NUM_W-2:0], 1'b0};
            rem_reg <= ge ? (DEN_W+1)'(shifted - {2'b00, den_in}) : shifted[DEN_W:0];
            quo_reg <= {quo_in[NUM_W-2:0], ge};
        end
    end

    assign v_out = v_reg;
    assign d_out = d_reg;
    assign idx_out = idx_reg;
    assign den_out = den_reg;
    assign num_out = num_reg;
    assign rem_out = rem_reg;
    assign quo_out = quo_reg;
endmodule

[sim/tb.sv]
// testbench for the time mantissa factor codec: directed table, random items, factor settings
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tmf_pkg::*;

    localparam int MANT_BITS = 5;
    localparam int NUM_FACT = 8;
    localparam longint MANT_MAX = (1 << MANT_BITS) - 1;
    localparam int LATENCY = NUM_FACT + 40;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        in_item_t  item;
        logic      known;
        out_item_t result;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_item_t in_item;
    logic out_valid;
    logic out_ready;
    out_item_t out_item;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [23:0] cfg_data;

    factor_t factor_tbl [REG_COUNT];
    out_item_t pending_codes [$];
    int errors;
    int accepted_items;
    int checked_items;
    longint cycles;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off;

    time_mantissa_factor_codec_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    function automatic longint unit_of(int idx);
        longint f;
        f = factor_tbl[idx];
        return (f == 0) ? 1 : f;
    endfunction

    function automatic out_item_t convert(in_item_t it);
        out_item_t r;
        longint t;
        longint f;
        longint mant;
        longint prod;
        int idx;
        r = '0;
        if (it.kind == KIND_ENCODE)
        begin
            t = it.time_ms;
            idx = NUM_FACT - 1;
            for (int i = NUM_FACT - 1; i >= 0; i--)
            begin
                if (t <= MANT_MAX * unit_of(i))
                begin
                    idx = i;
                end
            end
            f = unit_of(idx);
            mant = (2 * t + f) / (2 * f);
            if (mant > MANT_MAX)
            begin
                mant = MANT_MAX;
            end
            r.code_out = 8'((longint'(idx) << MANT_BITS) | mant);
        end
        else
        begin
            mant = it.code & MANT_MAX;
            idx = (it.code >> MANT_BITS) & (NUM_FACT - 1);
            prod = mant * unit_of(idx);
            r.time_out = (prod > TIME_MAX) ? TIME_MAX : prod[TOUT_W-1:0];
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycles <= cycles + 1;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        out_item_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_codes.size() == 0)
            begin
                $error("unexpected item code_out=%0d time_out=%0d",
                    out_item.code_out, out_item.time_out);
                errors++;
            end
            else
            begin
                exp_r = pending_codes.pop_front();
                checked_items++;
                if (out_item.code_out !== exp_r.code_out)
                begin
                    $error("code_out expected %0d actual %0d", exp_r.code_out,
                        out_item.code_out);
                    errors++;
                end
                if (out_item.time_out !== exp_r.time_out)
                begin
                    $error("time_out expected %0d actual %0d", exp_r.time_out,
                        out_item.time_out);
                    errors++;
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold-off when asked
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                out_ready <= 1'b0;
                hold_off--;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_item(in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        pending_codes.insert(pending_codes.size(), convert(it));
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        accepted_items++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_codes.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (LATENCY) @(negedge clk);
    endtask

    task automatic write_factor(int idx, factor_t val);
        cfg_we <= 1'b1;
        cfg_index <= idx[2:0];
        cfg_data <= val;
        factor_tbl[idx] = val;
        @(negedge clk);
    endtask

    function automatic in_item_t random_item();
        in_item_t it;
        int idx;
        it.kind = $urandom_range(1);
        it.code = $urandom_range(255);
        idx = $urandom_range(NUM_FACT - 1);
        case ($urandom_range(3))
            0: it.time_ms = $urandom();
            1: it.time_ms = $urandom_range(2 * 31);
            2: it.time_ms = unit_of(idx) * MANT_MAX + $urandom_range(2) - 1;
            default: it.time_ms = unit_of(idx) * $urandom_range(31)
                + unit_of(idx) / 2 + $urandom_range(1);
        endcase
        return it;
    endfunction

    initial
    begin
        stim_row_t rows [$];
        stim_row_t row;
        factor_t settings [4][REG_COUNT];
        errors = 0;
        accepted_items = 0;
        checked_items = 0;
        cycles = 0;
        hold_off = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        for (int i = 0; i < REG_COUNT; i++)
        begin
            factor_tbl[i] = reset_factor(i[2:0]);
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table; expected values read off for reset factors
        rows = '{
            '{'{KIND_ENCODE, 32'd0, 8'd0}, 1'b1, '{8'd0, 29'd0}},
            '{'{KIND_ENCODE, 32'd50, 8'd0}, 1'b1, '{8'd1, 29'd0}},
            '{'{KIND_ENCODE, 32'd49, 8'd0}, 1'b1, '{8'd0, 29'd0}},
            '{'{KIND_ENCODE, 32'd3100, 8'd0}, 1'b1, '{8'd31, 29'd0}},
            '{'{KIND_ENCODE, 32'd3101, 8'd0}, 1'b1, '{8'd35, 29'd0}},
            '{'{KIND_ENCODE, 32'd111600000, 8'd0}, 1'b1, '{8'd255, 29'd0}},
            '{'{KIND_ENCODE, 32'hFFFFFFFF, 8'd0}, 1'b1, '{8'd255, 29'd0}},
            '{'{KIND_DECODE, 32'hFFFFFFFF, 8'd0}, 1'b1, '{8'd0, 29'd0}},
            '{'{KIND_DECODE, 32'd0, 8'd255}, 1'b1, '{8'd0, 29'd111600000}},
            '{'{KIND_DECODE, 32'd0, 8'd31}, 1'b1, '{8'd0, 29'd3100}},
            '{'{KIND_DECODE, 32'd0, 8'd32}, 1'b1, '{8'd0, 29'd0}},
            '{'{KIND_ENCODE, 32'd155000, 8'd255}, 1'b0, '{8'd0, 29'd0}},
            '{'{KIND_ENCODE, 32'd7777777, 8'd170}, 1'b0, '{8'd0, 29'd0}},
            '{'{KIND_DECODE, 32'd123, 8'd85}, 1'b0, '{8'd0, 29'd0}},
            '{'{KIND_DECODE, 32'h55555555, 8'd170}, 1'b0, '{8'd0, 29'd0}}
        };
        foreach (rows[i])
        begin
            row = rows[i];
            if (row.known && convert(row.item) !== row.result)
            begin
                $error("table row %0d disagrees with predictor", i);
                errors++;
            end
            send_item(row.item);
        end
        drain();

        // settings: all max, all min/zero, mixed random, reset values
        for (int i = 0; i < REG_COUNT; i++)
        begin
            settings[0][i] = 24'hFFFFFF;
            settings[1][i] = (i % 2) ? 24'd0 : 24'd1;
            settings[2][i] = $urandom_range(24'hFFFFFF);
            settings[3][i] = reset_factor(i[2:0]);
        end
        for (int s = 0; s < 4; s++)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                write_factor(i, settings[s][i]);
            end
            cfg_we <= 1'b0;
            for (int p = 0; p < 4; p++)
            begin
                send_idle_pct = (p == 1 || p == 3) ? ((p == 3) ? 11 : 58) : 0;
                recv_stall_pct = (p == 2 || p == 3) ? ((p == 3) ? 11 : 58) : 0;
                if (s == 0 && p == 0)
                begin
                    hold_off = 200;
                end
                for (int k = 0; k < 46; k++)
                begin
                    send_item(random_item());
                end
            end
            drain();
        end

        $display("covered %0d items over directed extremes and 4 factor settings,",
            accepted_items);
        $display("%0d results checked with idle, stall and hold-off phases", checked_items);
        if (errors == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
